/* rtl/nprd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nprd_pkg
// Shared types and constants for the nucleotide stream decoder.
// ----------------------------------------------------------------------------
package nprd_pkg;

    localparam int CHAR_W     = 7;
    localparam int SLOTS      = 8;
    localparam int SLOT_IDX_W = $clog2(SLOTS);
    localparam int SLOT_CNT_W = $clog2(SLOTS + 1);
    localparam int REPS_W     = 4;

    localparam logic [7:0] ESC_BYTE         = 8'hFF;
    localparam logic [7:0] MODE_BYTE_PACKED = 8'd1;
    localparam logic [7:0] MODE_BYTE_DEGEN  = 8'd2;
    localparam logic [3:0] IUPAC_LAST_CODE  = 4'd12;
    localparam logic [SLOT_CNT_W-1:0] GROUP_SIZE = SLOT_CNT_W'(4);

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_PACKED = 2'd1,
        MODE_DEGEN  = 2'd2
    } mode_t;

    // index 0 = A, 1 = T, 2 = G, 3 = C
    localparam logic [3:0][CHAR_W-1:0] BASE_LETTERS = {
        7'h43, 7'h47, 7'h54, 7'h41
    };

    // R Y K M S W B D H V N - C, index 0 first
    localparam logic [12:0][CHAR_W-1:0] IUPAC_LETTERS = {
        7'h43, 7'h2D, 7'h4E, 7'h56, 7'h48, 7'h44, 7'h42,
        7'h57, 7'h53, 7'h4D, 7'h4B, 7'h59, 7'h52
    };

    // Results caused by one input byte: slot_cnt characters, the last one
    // repeated reps_m1 + 1 times.
    typedef struct packed {
        logic [SLOTS-1:0][CHAR_W-1:0] chars;
        logic [SLOT_CNT_W-1:0]        slot_cnt;
        logic [REPS_W-1:0]            reps_m1;
        logic                         err;
    } desc_t;

    typedef struct packed {
        logic job_valid;
        logic job_free;
    } emit_status_t;

endpackage

/* rtl/nprd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nprd_front
// Stream state and per-byte decode into a result descriptor.
// ----------------------------------------------------------------------------
module nprd_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [7:0]     in_byte,
    input  logic           end_of_stream,
    output nprd_pkg::desc_t desc
);

    nprd_pkg::mode_t mode_reg, mode_next;
    logic [3:0][1:0] pend_codes_reg, pend_codes_next;
    logic            pend_valid_reg, pend_valid_next;
    logic            await_reg, await_next;
    logic            latch_reg, latch_next;

    logic [3:0][nprd_pkg::CHAR_W-1:0] pend_letters;
    logic                             eos_flush;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            pend_letters[i] = nprd_pkg::BASE_LETTERS[pend_codes_reg[3-i]];
        end
    end

    always_comb
    begin
        mode_next       = mode_reg;
        pend_codes_next = pend_codes_reg;
        pend_valid_next = pend_valid_reg;
        await_next      = await_reg;
        latch_next      = latch_reg;
        desc            = '0;
        eos_flush       = 1'b0;

        if (latch_reg)
        begin
            desc.slot_cnt = nprd_pkg::SLOT_CNT_W'(1);
            desc.err      = 1'b1;
        end
        else if (mode_reg == nprd_pkg::MODE_IDLE)
        begin
            if (in_byte == nprd_pkg::MODE_BYTE_PACKED)
            begin
                mode_next = nprd_pkg::MODE_PACKED;
            end
            else if (in_byte == nprd_pkg::MODE_BYTE_DEGEN)
            begin
                mode_next = nprd_pkg::MODE_DEGEN;
            end
            else
            begin
                latch_next    = 1'b1;
                desc.slot_cnt = nprd_pkg::SLOT_CNT_W'(1);
                desc.err      = 1'b1;
            end
        end
        else if (await_reg)
        begin
            await_next = 1'b0;
            mode_next  = nprd_pkg::MODE_DEGEN;
            if (pend_valid_reg)
            begin
                pend_valid_next = 1'b0;
                for (int i = 0; i < 4; i++)
                begin
                    desc.chars[i] = pend_letters[i];
                end
                if (in_byte > 8'd4)
                begin
                    desc.slot_cnt = nprd_pkg::GROUP_SIZE;
                end
                else
                begin
                    desc.slot_cnt = nprd_pkg::SLOT_CNT_W'(in_byte[2:0]);
                end
            end
        end
        else if (mode_reg == nprd_pkg::MODE_PACKED)
        begin
            if (in_byte == nprd_pkg::ESC_BYTE)
            begin
                await_next = 1'b1;
            end
            else
            begin
                if (pend_valid_reg)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        desc.chars[i] = pend_letters[i];
                    end
                    desc.slot_cnt = nprd_pkg::GROUP_SIZE;
                end
                pend_codes_next = in_byte;
                pend_valid_next = 1'b1;
            end
        end
        else
        begin
            if (in_byte == nprd_pkg::ESC_BYTE)
            begin
                mode_next = nprd_pkg::MODE_PACKED;
            end
            else if (in_byte[3:0] > nprd_pkg::IUPAC_LAST_CODE)
            begin
                desc.slot_cnt = nprd_pkg::SLOT_CNT_W'(1);
                desc.err      = 1'b1;
            end
            else
            begin
                desc.chars[0] = nprd_pkg::IUPAC_LETTERS[in_byte[3:0]];
                desc.slot_cnt = nprd_pkg::SLOT_CNT_W'(1);
                desc.reps_m1  = in_byte[7:4];
            end
        end

        // end of stream: flush pending group, then back to reset state
        if (end_of_stream)
        begin
            eos_flush = !latch_next && pend_valid_next;
            if (eos_flush)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    if (desc.slot_cnt == '0)
                    begin
                        desc.chars[i] = nprd_pkg::BASE_LETTERS[pend_codes_next[3-i]];
                    end
                    else
                    begin
                        desc.chars[i+4] = nprd_pkg::BASE_LETTERS[pend_codes_next[3-i]];
                    end
                end
                desc.slot_cnt = desc.slot_cnt + nprd_pkg::GROUP_SIZE;
            end
            mode_next       = nprd_pkg::MODE_IDLE;
            pend_valid_next = 1'b0;
            await_next      = 1'b0;
            latch_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= nprd_pkg::MODE_IDLE;
            pend_valid_reg <= 1'b0;
            await_reg      <= 1'b0;
            latch_reg      <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg       <= mode_next;
            pend_valid_reg <= pend_valid_next;
            await_reg      <= await_next;
            latch_reg      <= latch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_codes_reg <= pend_codes_next;
        end
    end

endmodule

/* rtl/nprd_emit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nprd_emit
// Descriptor register and output register; walks one result per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module nprd_emit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  nprd_pkg::desc_t               desc_in,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic [nprd_pkg::CHAR_W-1:0]   out_char,
    output logic                          last_of_run,
    output logic                          error,
    output nprd_pkg::emit_status_t        status
);

    nprd_pkg::desc_t                   job_reg;
    logic                              job_valid_reg, job_valid_next;
    logic [nprd_pkg::SLOT_IDX_W-1:0]   slot_reg, slot_next;
    logic [nprd_pkg::REPS_W-1:0]       rep_reg, rep_next;
    logic                              out_valid_reg, out_valid_next;
    logic [nprd_pkg::CHAR_W-1:0]       out_char_reg;
    logic                              out_last_reg;
    logic                              out_err_reg;

    logic [nprd_pkg::SLOT_CNT_W-1:0]   last_full;
    logic [nprd_pkg::SLOT_IDX_W-1:0]   last_slot;
    logic                              out_free;
    logic                              issue;
    logic                              at_last_slot;
    logic                              is_last;
    logic                              job_done;

    assign last_full    = job_reg.slot_cnt - nprd_pkg::SLOT_CNT_W'(1);
    assign last_slot    = last_full[nprd_pkg::SLOT_IDX_W-1:0];
    assign out_free     = !out_valid_reg || !out_stall;
    assign issue        = job_valid_reg && out_free;
    assign at_last_slot = (slot_reg == last_slot);
    assign is_last      = at_last_slot && (rep_reg == job_reg.reps_m1);
    assign job_done     = issue && is_last;

    assign status.job_valid = job_valid_reg;
    assign status.job_free  = !job_valid_reg || job_done;

    always_comb
    begin
        if (load)
        begin
            job_valid_next = (desc_in.slot_cnt != '0);
        end
        else if (job_done)
        begin
            job_valid_next = 1'b0;
        end
        else
        begin
            job_valid_next = job_valid_reg;
        end

        slot_next = slot_reg;
        rep_next  = rep_reg;
        if (load || job_done)
        begin
            slot_next = '0;
            rep_next  = '0;
        end
        else if (issue)
        begin
            if (at_last_slot)
            begin
                rep_next = rep_reg + nprd_pkg::REPS_W'(1);
            end
            else
            begin
                slot_next = slot_reg + nprd_pkg::SLOT_IDX_W'(1);
            end
        end

        if (issue)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            slot_reg      <= '0;
            rep_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            slot_reg      <= slot_next;
            rep_reg       <= rep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= desc_in;
        end
        if (issue)
        begin
            out_char_reg <= job_reg.chars[slot_reg];
            out_last_reg <= is_last;
            out_err_reg  <= job_reg.err;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign last_of_run = out_last_reg;
    assign error       = out_err_reg;

endmodule

/* rtl/nucleotide_pack_rle_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nucleotide_pack_rle_decoder
// Decodes a packed 2-bit / degenerate IUPAC run byte stream into ASCII.
// ----------------------------------------------------------------------------
// An input byte is decoded in the cycle it is accepted into a descriptor of
// 0 to 16 characters; the output stage then delivers one character per cycle
// through a registered output while out_stall is low. A byte holds the
// output stage until its results are out: 4 for a typical packed byte, up
// to 16 for a degenerate run, up to 8 for a packed byte ending the stream.
// Bytes without results (mode byte, escape, count with nothing pending) are
// taken in every cycle. The next byte is accepted in the same cycle that the
// last character of the current one moves to the output register.
module nucleotide_pack_rle_decoder
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  in_byte,
    input  logic                        end_of_stream,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [nprd_pkg::CHAR_W-1:0] out_char,
    output logic                        last_of_run,
    output logic                        error
);

    nprd_pkg::desc_t        desc;
    nprd_pkg::emit_status_t status;
    logic                   accept;

    assign in_stall = !status.job_free;
    assign accept   = in_valid && !in_stall;

    nprd_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_byte       (in_byte),
        .end_of_stream (end_of_stream),
        .desc          (desc)
    );

    nprd_emit u_emit
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept),
        .desc_in     (desc),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_char    (out_char),
        .last_of_run (last_of_run),
        .error       (error),
        .status      (status)
    );

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> status.job_valid)
        else $error("input stalled with no transaction in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (desc.slot_cnt != '0) |=> status.job_valid)
        else $error("accepted transaction with results was dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> last_of_run && (out_char == '0))
        else $error("error result not a single zero character");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && desc.err |-> (desc.slot_cnt == nprd_pkg::SLOT_CNT_W'(1)))
        else $error("error descriptor carries extra characters");
`endif

endmodule
